@@ sv/metropolis_spin_update_top_defines.svh @@
// assertion macros for the metropolis spin update block
`ifndef METROPOLIS_SPIN_UPDATE_TOP_DEFINES_SVH
`define METROPOLIS_SPIN_UPDATE_TOP_DEFINES_SVH

// checked outside reset
`define MSPIN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define MSPIN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/mspin_pkg.sv @@
// package: constants, control structs and exp table for the spin update block
`timescale 1ns / 1ps
package mspin_pkg;

  localparam int MAX_NODES       = 1024;
  localparam int MAX_DEGREE      = 16;
  localparam int WEIGHT_BITS     = 16;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int NODE_W  = 10;
  localparam int SLOT_W  = 4;
  localparam int DEG_W   = 5;
  localparam int RND_W   = 16;
  localparam int TEMP_W  = 16;
  localparam int EDGE_AW = NODE_W + SLOT_W;
  localparam int ACC_W   = 21;
  localparam int SUM_W   = 20;
  localparam int NUM_W   = 21;
  localparam int DEN_W   = DEG_W + TEMP_W;
  localparam int Q_W     = 8;
  localparam int TRIAL_W = DEN_W + Q_W;

  localparam logic [TEMP_W-1:0] TEMP_RESET = 16'd256;
  localparam logic [DEG_W-1:0]  DEG_MAX    = 5'd16;

  localparam logic [1:0] CMD_SPIN   = 2'd0;
  localparam logic [1:0] CMD_EDGE   = 2'd1;
  localparam logic [1:0] CMD_DEGREE = 2'd2;
  localparam logic [1:0] CMD_UPDATE = 2'd3;

  typedef logic [15:0] exp_tab_t [EXP_TABLE_DEPTH];

  // long division for the table build
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] quo;
    logic [64:0] part;
    quo  = '0;
    part = '0;
    for (int i = 63; i >= 0; i--) begin
      part = {part[63:0], a[i]};
      if (part >= {1'b0, b}) begin
        part   = part - {1'b0, b};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t   tab;
    logic [63:0] base;
    logic [63:0] term;
    logic [63:0] p;
    logic [63:0] r;
    base = 64'd1 << 32;
    term = 64'd1 << 32;
    p    = 64'd1 << 32;
    for (int k = 1; k <= 24; k++) begin
      term = udiv64(term * 64'd16, 64'(EXP_TABLE_DEPTH) * 64'(k));
      if (k[0]) base = base - term;
      else base = base + term;
    end
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      if (i > 0) p = (p * base + (64'd1 << 31)) >> 32;
      r = (p + (64'd1 << 15)) >> 16;
      tab[i] = (r > 64'd65535) ? 16'hFFFF : r[15:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  typedef struct packed {
    logic       in_ready;
    logic       latch_deg;
    logic       walk;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic [2:0] div_sh;
    logic       lut;
    logic       out_load;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    logic in_upd;
    logic walk_done;
    logic out_free;
  } stat_t;

endpackage

@@ sv/mspin_in_if.sv @@
// input item channel
`timescale 1ns / 1ps
interface mspin_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      cmd;
  logic [mspin_pkg::NODE_W-1:0]    node;
  logic [mspin_pkg::SLOT_W-1:0]    slot;
  logic [mspin_pkg::NODE_W-1:0]    neighbour;
  logic signed [mspin_pkg::WEIGHT_BITS-1:0] weight;
  logic                            spin_in;
  logic [mspin_pkg::DEG_W-1:0]     degree;
  logic [mspin_pkg::RND_W-1:0]     random;
  modport source (output valid, cmd, node, slot, neighbour, weight, spin_in, degree, random,
                  input ready);
  modport sink (input valid, cmd, node, slot, neighbour, weight, spin_in, degree, random,
                output ready);
endinterface

@@ sv/mspin_out_if.sv @@
// result item channel
`timescale 1ns / 1ps
interface mspin_out_if;
  logic                         valid;
  logic                         ready;
  logic [mspin_pkg::NODE_W-1:0] updated_node;
  logic                         spin_out;
  logic                         flipped;
  modport source (output valid, updated_node, spin_out, flipped, input ready);
  modport sink (input valid, updated_node, spin_out, flipped, output ready);
endinterface

@@ sv/mspin_cfg_if.sv @@
// configuration write channel
`timescale 1ns / 1ps
interface mspin_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mspin_pkg::TEMP_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/mspin_ctrl.sv @@
// controller state machine for the spin update sequence
`timescale 1ns / 1ps
module mspin_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  mspin_pkg::stat_t  st,
  output mspin_pkg::ctl_t   ctl
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEG   = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DINIT = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_LUT   = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  logic [3:0] state, state_next;
  logic [2:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    ctl.div_sh = cnt;
    case (state)
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (st.in_fire && st.in_upd) state_next = S_DEG;
      end
      S_DEG: begin
        ctl.latch_deg = 1'b1;
        state_next    = S_WALK;
      end
      S_WALK: begin
        ctl.walk = 1'b1;
        if (st.walk_done) state_next = S_MUL;
      end
      S_MUL: begin
        ctl.mul    = 1'b1;
        state_next = S_DINIT;
      end
      S_DINIT: begin
        ctl.div_init = 1'b1;
        cnt_next     = 3'd7;
        state_next   = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        cnt_next     = cnt - 3'd1;
        if (cnt == 3'd0) state_next = S_LUT;
      end
      S_LUT: begin
        ctl.lut    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ sv/mspin_dp.sv @@
// datapath: stores, neighbour walk, divider, table test and result register
`timescale 1ns / 1ps
module mspin_dp (
  input  logic             clk,
  input  logic             rst,
  mspin_in_if.sink         items,
  mspin_out_if.source      results,
  mspin_cfg_if.sink        cfg,
  input  mspin_pkg::ctl_t  ctl,
  output mspin_pkg::stat_t st
);

  logic                                spin_mem [mspin_pkg::MAX_NODES];
  logic [mspin_pkg::DEG_W-1:0]         deg_mem  [mspin_pkg::MAX_NODES];
  logic [mspin_pkg::NODE_W-1:0]        nbr_mem  [mspin_pkg::MAX_NODES*mspin_pkg::MAX_DEGREE];
  logic [mspin_pkg::WEIGHT_BITS-1:0]   wgt_mem  [mspin_pkg::MAX_NODES*mspin_pkg::MAX_DEGREE];

  logic [mspin_pkg::TEMP_W-1:0]        temperature;
  logic [mspin_pkg::NODE_W-1:0]        node_q;
  logic [mspin_pkg::RND_W-1:0]         rnd_q;
  logic                                s_own;
  logic [mspin_pkg::DEG_W-1:0]         d_sat;
  logic [mspin_pkg::DEG_W-1:0]         j;
  logic                                ev, sv;
  logic [mspin_pkg::NODE_W-1:0]        nbr_rd;
  logic [mspin_pkg::WEIGHT_BITS-1:0]   w_rd, w_q;
  logic                                spin_rd;
  logic [mspin_pkg::DEG_W-1:0]         deg_rd;
  logic signed [mspin_pkg::ACC_W-1:0]  acc;
  logic signed [mspin_pkg::ACC_W-1:0]  w_ext, e_val;
  logic signed [mspin_pkg::SUM_W-1:0]  sum_sat;
  logic                                e_le0;
  logic [mspin_pkg::NUM_W-1:0]         rem;
  logic [mspin_pkg::DEN_W-1:0]         den;
  logic [mspin_pkg::TEMP_W-1:0]        t_eff;
  logic [mspin_pkg::Q_W-1:0]           q;
  logic                                over;
  logic                                flip_q;
  logic [mspin_pkg::TRIAL_W-1:0]       trial;
  logic                                issue;
  logic                                spin_we;
  logic [mspin_pkg::NODE_W-1:0]        spin_wa, spin_ra;
  logic                                spin_wd;
  logic                                out_valid;
  logic [mspin_pkg::NODE_W-1:0]        out_node;
  logic                                out_spin, out_flip;

  assign items.ready  = ctl.in_ready;
  assign cfg.ready    = 1'b1;
  assign st.in_fire   = items.valid && ctl.in_ready;
  assign st.in_upd    = items.cmd == mspin_pkg::CMD_UPDATE;
  assign st.walk_done = (j == d_sat) && !ev && !sv;
  assign st.out_free  = !out_valid || results.ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) temperature <= mspin_pkg::TEMP_RESET;
    else if (cfg.valid) temperature <= cfg.data;
  end

  // spin store: one write port, one read port
  assign issue   = ctl.walk && (j < d_sat);
  assign spin_we = (st.in_fire && items.cmd == mspin_pkg::CMD_SPIN) || (ctl.out_load && flip_q);
  assign spin_wa = ctl.out_load ? node_q : items.node;
  assign spin_wd = ctl.out_load ? !s_own : items.spin_in;
  assign spin_ra = ctl.in_ready ? items.node : nbr_rd;

  always_ff @(posedge clk) begin
    if (spin_we) spin_mem[spin_wa] <= spin_wd;
    spin_rd <= spin_mem[spin_ra];
  end

  always_ff @(posedge clk) begin
    if (st.in_fire && items.cmd == mspin_pkg::CMD_DEGREE) deg_mem[items.node] <= items.degree;
    deg_rd <= deg_mem[items.node];
  end

  always_ff @(posedge clk) begin
    if (st.in_fire && items.cmd == mspin_pkg::CMD_EDGE) begin
      nbr_mem[{items.node, items.slot}] <= items.neighbour;
      wgt_mem[{items.node, items.slot}] <= items.weight;
    end
    if (issue) begin
      nbr_rd <= nbr_mem[{node_q, j[mspin_pkg::SLOT_W-1:0]}];
      w_rd   <= wgt_mem[{node_q, j[mspin_pkg::SLOT_W-1:0]}];
    end
  end

  // walk pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= 1'b0;
      sv <= 1'b0;
    end else begin
      ev <= issue;
      sv <= ev;
    end
  end

  assign w_ext = mspin_pkg::ACC_W'(signed'(w_q));

  always_ff @(posedge clk) begin
    if (st.in_fire) begin
      node_q <= items.node;
      rnd_q  <= items.random;
    end
    if (ctl.latch_deg) begin
      s_own <= spin_rd;
      d_sat <= (deg_rd > mspin_pkg::DEG_MAX) ? mspin_pkg::DEG_MAX : deg_rd;
      j     <= '0;
      acc   <= '0;
    end else begin
      if (issue) j <= j + 5'd1;
      if (sv) acc <= spin_rd ? acc + w_ext : acc - w_ext;
    end
    w_q <= w_rd;
  end

  // saturate, sign by own spin, form numerator and denominator
  always_comb begin
    if (acc > mspin_pkg::ACC_W'(signed'(20'sh7FFFF))) sum_sat = 20'sh7FFFF;
    else sum_sat = acc[mspin_pkg::SUM_W-1:0];
    e_val = s_own ? mspin_pkg::ACC_W'(sum_sat) : -mspin_pkg::ACC_W'(sum_sat);
    t_eff = (temperature == '0) ? 16'd1 : temperature;
    trial = mspin_pkg::TRIAL_W'(den) << ctl.div_sh;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      e_le0 <= e_val <= 0;
      rem   <= mspin_pkg::NUM_W'({e_val[mspin_pkg::ACC_W-2:0], 1'b0});
      den   <= mspin_pkg::DEN_W'(d_sat) * mspin_pkg::DEN_W'(t_eff);
    end
    if (ctl.div_init) begin
      over <= mspin_pkg::TRIAL_W'(rem) >= (mspin_pkg::TRIAL_W'(den) << mspin_pkg::Q_W);
      q    <= '0;
    end
    if (ctl.div_step) begin
      if (mspin_pkg::TRIAL_W'(rem) >= trial) begin
        rem        <= rem - trial[mspin_pkg::NUM_W-1:0];
        q[ctl.div_sh] <= 1'b1;
      end
    end
    if (ctl.lut)
      flip_q <= (d_sat != '0) && (e_le0 || (!over && rnd_q < mspin_pkg::EXP_TAB[q]));
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ctl.out_load) out_valid <= 1'b1;
    else if (results.ready) out_valid <= 1'b0;
    if (ctl.out_load) begin
      out_node <= node_q;
      out_spin <= s_own ^ flip_q;
      out_flip <= flip_q;
    end
  end

  assign results.valid        = out_valid;
  assign results.updated_node = out_node;
  assign results.spin_out     = out_spin;
  assign results.flipped      = out_flip;

endmodule

@@ sv/metropolis_spin_update_top.sv @@
// top level of the metropolis spin update block
// Write beats (spin, neighbour slot, degree) are taken back to back while idle. An update beat
// passes through the neighbour walk, the divider and the table test before its result is loaded,
// and waits for the output to be free: the neighbour walk reads the edge store one slot per cycle
// through a two-stage read pipeline, then an 8-step restoring divider forms the table index.
// The result waits in an output register, and a new beat is taken while it waits.
`timescale 1ns / 1ps
`include "metropolis_spin_update_top_defines.svh"
module metropolis_spin_update_top (
  input logic         clk,
  input logic         rst,
  mspin_in_if.sink    items,
  mspin_out_if.source results,
  mspin_cfg_if.sink   cfg
);

  mspin_pkg::ctl_t  ctl;
  mspin_pkg::stat_t st;

  mspin_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .ctl (ctl)
  );

  mspin_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg),
    .ctl     (ctl),
    .st      (st)
  );

  `MSPIN_ASSERT(a_load_free, ctl.out_load |-> st.out_free, "result loaded over a waiting beat")
  `MSPIN_ASSERT(a_walk_busy, ctl.walk |-> !items.ready, "input taken during neighbour walk")
  `MSPIN_ASSERT_ALWAYS(a_ready_after_rst, $past(rst) |-> items.ready, "not ready after reset")

endmodule

@@ tb/metropolis_spin_update_top_test.sv @@
// testbench for metropolis_spin_update_top: directed table, random load/update mix, predictor
`timescale 1ns / 1ps
module metropolis_spin_update_top_test;
  import mspin_pkg::*;

  typedef struct {
    logic [1:0] cmd;
    logic [NODE_W-1:0] node;
    logic [SLOT_W-1:0] slot;
    logic [NODE_W-1:0] neighbour;
    logic signed [WEIGHT_BITS-1:0] weight;
    logic spin_in;
    logic [DEG_W-1:0] degree;
    logic [RND_W-1:0] random;
  } stim_t;

  typedef struct {
    logic [NODE_W-1:0] node;
    logic spin;
    logic flipped;
  } result_t;

  typedef struct {
    stim_t s;
    bit typed;
    result_t r;
  } row_t;

  localparam int POOL_N = 16;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  mspin_in_if items_if ();
  mspin_out_if results_if ();
  mspin_cfg_if cfg_if ();

  metropolis_spin_update_top i_dut (
    .clk(clk),
    .rst(rst),
    .items(items_if.sink),
    .results(results_if.source),
    .cfg(cfg_if.sink)
  );

  // model state
  logic [15:0] decay_lut [EXP_TABLE_DEPTH];
  logic [TEMP_W-1:0] temp_q;
  logic spin_mem [MAX_NODES];
  logic [NODE_W-1:0] nbr_mem [MAX_NODES*MAX_DEGREE];
  logic signed [WEIGHT_BITS-1:0] wt_mem [MAX_NODES*MAX_DEGREE];
  logic [DEG_W-1:0] deg_mem [MAX_NODES];

  result_t pending_spins [$];
  int errors;
  int burst_left;
  int max_gap;
  bit hold_go;
  int hold_left;
  int stall_mode;
  int stall_cnt;
  logic [NODE_W-1:0] pool [POOL_N];

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void build_decay_lut();
    longint unsigned b;
    longint unsigned t;
    longint unsigned p;
    longint unsigned r;
    b = 64'd1 << 32;
    t = 64'd1 << 32;
    p = 64'd1 << 32;
    for (int k = 1; k <= 24; k++) begin
      t = (t * 16) / (EXP_TABLE_DEPTH * k);
      b = (k & 1) ? b - t : b + t;
    end
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      if (i > 0) p = (p * b + (64'd1 << 31)) >> 32;
      r = (p + (64'd1 << 15)) >> 16;
      decay_lut[i] = (r > 65535) ? 16'hFFFF : r[15:0];
    end
  endfunction

  function automatic void apply_item(input stim_t s, output bit has, output result_t r);
    int unsigned d;
    int unsigned a;
    longint sum;
    longint e;
    longint unsigned num;
    longint unsigned den;
    longint unsigned k;
    bit flip;
    has = 0;
    r = '{default: '0};
    flip = 0;
    sum = 0;
    case (s.cmd)
      CMD_SPIN: spin_mem[s.node] = s.spin_in;
      CMD_EDGE: begin
        a = s.node * MAX_DEGREE + s.slot;
        nbr_mem[a] = s.neighbour;
        wt_mem[a] = s.weight;
      end
      CMD_DEGREE: deg_mem[s.node] = s.degree;
      default: begin
        d = (deg_mem[s.node] > MAX_DEGREE) ? MAX_DEGREE : deg_mem[s.node];
        for (int j = 0; j < d; j++) begin
          a = s.node * MAX_DEGREE + j;
          sum += spin_mem[nbr_mem[a]] ? longint'(wt_mem[a]) : -longint'(wt_mem[a]);
        end
        if (sum > 524287) sum = 524287;
        if (sum < -524288) sum = -524288;
        if (d > 0) begin
          e = spin_mem[s.node] ? sum : -sum;
          if (e <= 0) flip = 1;
          else begin
            num = 2 * e * EXP_TABLE_DEPTH;
            den = 64'(256 * d * ((temp_q == 0) ? 1 : temp_q));
            k = num / den;
            if (k < EXP_TABLE_DEPTH && s.random < decay_lut[k]) flip = 1;
          end
        end
        if (flip) spin_mem[s.node] = ~spin_mem[s.node];
        has = 1;
        r.node = s.node;
        r.spin = spin_mem[s.node];
        r.flipped = flip;
      end
    endcase
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  task automatic write_temperature(input logic [TEMP_W-1:0] t);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= t;
    do @(posedge clk); while (!cfg_if.ready);
    temp_q = t;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_beat(input stim_t s, input bit typed, input result_t tr);
    bit has;
    result_t r;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      repeat (gap) begin
        @(negedge clk);
        items_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    items_if.valid <= 1'b1;
    items_if.cmd <= s.cmd;
    items_if.node <= s.node;
    items_if.slot <= s.slot;
    items_if.neighbour <= s.neighbour;
    items_if.weight <= s.weight;
    items_if.spin_in <= s.spin_in;
    items_if.degree <= s.degree;
    items_if.random <= s.random;
    do @(posedge clk); while (!items_if.ready);
    apply_item(s, has, r);
    if (has) pending_spins.push_back(typed ? tr : r);
  endtask

  task automatic drain();
    @(negedge clk);
    items_if.valid <= 1'b0;
    while (pending_spins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic stim_t mk(input logic [1:0] c, input int n, input int sl, input int nb,
                               input int w, input bit sp, input int dg, input int rn);
    stim_t s;
    s.cmd = c;
    s.node = NODE_W'(n);
    s.slot = SLOT_W'(sl);
    s.neighbour = NODE_W'(nb);
    s.weight = WEIGHT_BITS'(w);
    s.spin_in = sp;
    s.degree = DEG_W'(dg);
    s.random = RND_W'(rn);
    return s;
  endfunction

  function automatic stim_t noise_fields();
    stim_t s;
    s.cmd = 2'($urandom_range(0, 3));
    s.node = NODE_W'($urandom);
    s.slot = SLOT_W'($urandom);
    s.neighbour = NODE_W'($urandom);
    s.weight = WEIGHT_BITS'($urandom);
    s.spin_in = 1'($urandom);
    s.degree = DEG_W'($urandom);
    s.random = RND_W'($urandom);
    return s;
  endfunction

  function automatic logic signed [WEIGHT_BITS-1:0] pick_weight();
    int m;
    m = $urandom_range(0, 9);
    if (m < 5) return WEIGHT_BITS'(int'($urandom_range(0, 600)) - 300);
    if (m < 8) return WEIGHT_BITS'($urandom);
    return (m == 8) ? 16'sh7FFF : 16'sh8000;
  endfunction

  function automatic bit in_pool(input logic [NODE_W-1:0] n);
    foreach (pool[i]) if (pool[i] == n) return 1;
    return 0;
  endfunction

  task automatic random_beats(input int count);
    stim_t s;
    int r;
    result_t none;
    none = '{default: '0};
    for (int i = 0; i < count; i++) begin
      s = noise_fields();
      r = $urandom_range(0, 99);
      if (r < 65) begin
        s.cmd = CMD_UPDATE;
        s.node = pool[$urandom_range(0, POOL_N-1)];
        if ($urandom_range(0, 3) == 0) s.random = RND_W'($urandom_range(0, 3) * 16'h5555);
      end else if (r < 75) begin
        s.cmd = CMD_SPIN;
        s.node = pool[$urandom_range(0, POOL_N-1)];
      end else if (r < 87) begin
        s.cmd = CMD_EDGE;
        s.node = pool[$urandom_range(0, POOL_N-1)];
        s.neighbour = pool[$urandom_range(0, POOL_N-1)];
        s.weight = pick_weight();
      end else if (r < 92) begin
        s.cmd = CMD_DEGREE;
        s.node = pool[$urandom_range(0, POOL_N-1)];
      end else begin
        s.cmd = 2'($urandom_range(0, 2));
        if (in_pool(s.node)) s.cmd = CMD_SPIN;
      end
      send_beat(s, 0, none);
    end
  endtask

  // receiver side
  always @(negedge clk) begin
    stall_cnt++;
    if (stall_cnt % 250 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      results_if.ready <= 1'b0;
    end else if (hold_go) begin
      hold_go = 0;
      hold_left = 400;
      results_if.ready <= 1'b0;
    end else if (stall_mode == 0) begin
      results_if.ready <= 1'b1;
    end else if (stall_mode == 1) begin
      results_if.ready <= (stall_cnt % 3 != 0);
    end else begin
      results_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    result_t x;
    if (!rst && results_if.valid && results_if.ready) begin
      if (pending_spins.size() == 0) begin
        report($sformatf("unexpected beat node %0d", results_if.updated_node));
      end else begin
        x = pending_spins.pop_front();
        if (results_if.updated_node !== x.node)
          report($sformatf("updated_node %0d, want %0d", results_if.updated_node, x.node));
        if (results_if.spin_out !== x.spin)
          report($sformatf("spin_out %b, want %b (node %0d)", results_if.spin_out, x.spin,
                           x.node));
        if (results_if.flipped !== x.flipped)
          report($sformatf("flipped %b, want %b (node %0d)", results_if.flipped, x.flipped,
                           x.node));
      end
    end
  end

  initial begin
    row_t rows [$];
    result_t none;
    stim_t s;
    logic [TEMP_W-1:0] temps [5];
    none = '{default: '0};
    errors = 0;
    burst_left = 0;
    max_gap = 0;
    hold_go = 0;
    hold_left = 0;
    stall_mode = 0;
    stall_cnt = 0;
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.cmd = CMD_SPIN;
    items_if.node = '0;
    items_if.slot = '0;
    items_if.neighbour = '0;
    items_if.weight = '0;
    items_if.spin_in = 1'b0;
    items_if.degree = '0;
    items_if.random = '0;
    results_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    build_decay_lut();
    temp_q = TEMP_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    rows.push_back('{mk(CMD_SPIN, 0, 15, 1023, -1, 1, 31, 65535), 0, none});
    rows.push_back('{mk(CMD_SPIN, 1, 0, 0, 0, 1, 0, 0), 0, none});
    rows.push_back('{mk(CMD_SPIN, 2, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(CMD_SPIN, 1023, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(CMD_DEGREE, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0), 1, '{10'd0, 1'b1, 1'b0}});
    rows.push_back('{mk(CMD_DEGREE, 1023, 0, 0, 0, 0, 1, 0), 0, none});
    rows.push_back('{mk(CMD_EDGE, 1023, 0, 1, 32767, 0, 0, 0), 0, none});
    rows.push_back('{mk(CMD_UPDATE, 1023, 0, 0, 0, 0, 0, 0), 1, '{10'd1023, 1'b1, 1'b1}});
    rows.push_back('{mk(CMD_DEGREE, 1, 0, 0, 0, 0, 2, 0), 0, none});
    rows.push_back('{mk(CMD_EDGE, 1, 0, 1023, -32768, 0, 0, 0), 0, none});
    rows.push_back('{mk(CMD_EDGE, 1, 1, 2, -32768, 0, 0, 0), 0, none});
    rows.push_back('{mk(CMD_UPDATE, 1, 0, 0, 0, 0, 0, 65535), 1, '{10'd1, 1'b0, 1'b1}});
    rows.push_back('{mk(CMD_DEGREE, 2, 0, 0, 0, 0, 1, 0), 0, none});
    rows.push_back('{mk(CMD_EDGE, 2, 0, 0, 4096, 0, 0, 0), 0, none});
    rows.push_back('{mk(CMD_UPDATE, 2, 0, 0, 0, 0, 0, 65535), 1, '{10'd2, 1'b1, 1'b1}});
    rows.push_back('{mk(CMD_UPDATE, 2, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(CMD_UPDATE, 2, 0, 0, 0, 0, 0, 65535), 0, none});
    rows.push_back('{mk(CMD_EDGE, 1023, 15, 1023, -32768, 1, 0, 0), 0, none});
    rows.push_back('{mk(CMD_UPDATE, 1023, 0, 0, 0, 0, 0, 65535), 0, none});
    rows.push_back('{mk(CMD_UPDATE, 1, 0, 0, 0, 0, 0, 0), 0, none});
    foreach (rows[i]) send_beat(rows[i].s, rows[i].typed, rows[i].r);
    drain();

    // working set of nodes, each fully loaded before any update
    pool[0] = '0;
    pool[1] = NODE_W'(1023);
    for (int i = 2; i < POOL_N; i++) pool[i] = NODE_W'($urandom_range(3, 1022));
    foreach (pool[i]) begin
      s = noise_fields();
      s.cmd = CMD_SPIN;
      s.node = pool[i];
      send_beat(s, 0, none);
      s = noise_fields();
      s.cmd = CMD_DEGREE;
      s.node = pool[i];
      send_beat(s, 0, none);
      for (int j = 0; j < MAX_DEGREE; j++) begin
        s = noise_fields();
        s.cmd = CMD_EDGE;
        s.node = pool[i];
        s.slot = SLOT_W'(j);
        s.neighbour = pool[$urandom_range(0, POOL_N-1)];
        s.weight = pick_weight();
        send_beat(s, 0, none);
      end
    end
    drain();

    temps[0] = 16'd256;
    temps[1] = 16'd1;
    temps[2] = 16'd65535;
    temps[3] = TEMP_W'($urandom_range(16, 2000));
    temps[4] = TEMP_W'($urandom_range(1, 65535));
    foreach (temps[p]) begin
      write_temperature(temps[p]);
      max_gap = (p == 0) ? 0 : 6;
      if (p == 1) hold_go = 1;
      random_beats(200);
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
